// ----- src/round_robin_quantum_scheduler_macros.svh -----
// assertion macros for the round-robin quantum scheduler checker
// expects clk and rst_n in the scope where a macro is used
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_MACROS_SVH

// same-cycle implication
`define RRQS_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("rrqs check failed");

// next-cycle implication
`define RRQS_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("rrqs check failed");

`endif

// ----- src/rrqs_pkg.sv -----
// shared types and constants for the round-robin quantum scheduler
// used by controller, datapath and top level
package rrqs_pkg;

  localparam int MAX_SLOTS_DEF = 16;
  localparam int QUANT_W       = 9;
  localparam logic [QUANT_W-1:0] QUANT_MAX = 9'd511;

  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_ADD   = 3'd1;
  localparam logic [2:0] REQ_YIELD = 3'd2;
  localparam logic [2:0] REQ_END   = 3'd3;
  localparam logic [2:0] REQ_SET   = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NO_READY = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  localparam logic [1:0] SS_READY   = 2'd0;
  localparam logic [1:0] SS_BLOCKED = 2'd1;
  localparam logic [1:0] SS_DEAD    = 2'd2;
  localparam logic [1:0] SS_INVALID = 2'd3;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_EMPTY,
    OP_TICK0,
    OP_RA,
    OP_RAF,
    OP_WALK,
    OP_YLD0,
    OP_YLD1,
    OP_YLD2,
    OP_END0,
    OP_GIFT0,
    OP_GIFT1,
    OP_ADDSCAN,
    OP_ADDLINK,
    OP_SETRD,
    OP_SETCHK,
    OP_FINRD,
    OP_FIN
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic ne;
    logic req_tick;
    logic req_add;
    logic req_yield;
    logic req_end;
    logic set_go;
    logic tick_go;
    logic slot_ready;
    logic ring_done;
    logic last;
    logic free;
    logic scan_last;
    logic match;
    logic out_free;
  } stat_t;

endpackage

// ----- src/rrqs_ctrl.sv -----
// controller state machine of the round-robin quantum scheduler
// depends on rrqs_pkg; drives micro-op commands into rrqs_dp
module rrqs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  rrqs_pkg::stat_t stat,
  output rrqs_pkg::cmd_t  cmd
);

  typedef enum logic [14:0] {
    S_IDLE     = 15'b000000000000001,
    S_DISP     = 15'b000000000000010,
    S_RA       = 15'b000000000000100,
    S_RAF      = 15'b000000000001000,
    S_WALK     = 15'b000000000010000,
    S_YLD_WR   = 15'b000000000100000,
    S_YLD_Z    = 15'b000000001000000,
    S_ADD_SCAN = 15'b000000010000000,
    S_ADD_LINK = 15'b000000100000000,
    S_SET_RD   = 15'b000001000000000,
    S_SET_CHK  = 15'b000010000000000,
    S_GIFT_RD  = 15'b000100000000000,
    S_GIFT_WR  = 15'b001000000000000,
    S_FIN_RD   = 15'b010000000000000,
    S_FIN      = 15'b100000000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = rrqs_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = rrqs_pkg::OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        priority if ((stat.req_tick || stat.req_yield || stat.req_end) && !stat.ne) begin
          cmd.op    = rrqs_pkg::OP_EMPTY;
          state_nxt = S_FIN_RD;
        end else if (stat.req_tick) begin
          cmd.op    = rrqs_pkg::OP_TICK0;
          state_nxt = stat.tick_go ? S_RA : S_FIN_RD;
        end else if (stat.req_yield) begin
          cmd.op    = rrqs_pkg::OP_YLD0;
          state_nxt = S_YLD_WR;
        end else if (stat.req_end) begin
          cmd.op    = rrqs_pkg::OP_END0;
          state_nxt = stat.last ? S_FIN_RD : S_RA;
        end else if (stat.req_add) begin
          cmd.op = rrqs_pkg::OP_ADDSCAN;
          priority if (stat.free) begin
            state_nxt = stat.ne ? S_ADD_LINK : S_FIN_RD;
          end else if (stat.scan_last) begin
            state_nxt = S_FIN_RD;
          end else begin
            state_nxt = S_ADD_SCAN;
          end
        end else if (stat.set_go) begin
          cmd.op    = rrqs_pkg::OP_SETRD;
          state_nxt = S_SET_CHK;
        end else begin
          state_nxt = S_FIN_RD;
        end
      end
      S_RA: begin
        cmd.op = rrqs_pkg::OP_RA;
        priority if (stat.slot_ready) begin
          state_nxt = S_RAF;
        end else if (stat.ring_done) begin
          state_nxt = stat.req_end ? S_GIFT_RD : S_FIN_RD;
        end else begin
          state_nxt = S_RA;
        end
      end
      S_RAF: begin
        cmd.op    = rrqs_pkg::OP_RAF;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        cmd.op = rrqs_pkg::OP_WALK;
        if (stat.slot_ready) begin
          state_nxt = stat.req_end ? S_GIFT_RD : S_FIN_RD;
        end
      end
      S_YLD_WR: begin
        cmd.op    = rrqs_pkg::OP_YLD1;
        state_nxt = S_YLD_Z;
      end
      S_YLD_Z: begin
        cmd.op    = rrqs_pkg::OP_YLD2;
        state_nxt = S_FIN_RD;
      end
      S_ADD_SCAN: begin
        cmd.op = rrqs_pkg::OP_ADDSCAN;
        priority if (stat.free) begin
          state_nxt = stat.ne ? S_ADD_LINK : S_FIN_RD;
        end else if (stat.scan_last) begin
          state_nxt = S_FIN_RD;
        end else begin
          state_nxt = S_ADD_SCAN;
        end
      end
      S_ADD_LINK: begin
        cmd.op    = rrqs_pkg::OP_ADDLINK;
        state_nxt = S_FIN_RD;
      end
      S_SET_RD: begin
        cmd.op    = rrqs_pkg::OP_SETRD;
        state_nxt = S_SET_CHK;
      end
      S_SET_CHK: begin
        cmd.op    = rrqs_pkg::OP_SETCHK;
        state_nxt = (stat.match || stat.scan_last) ? S_FIN_RD : S_SET_RD;
      end
      S_GIFT_RD: begin
        cmd.op    = rrqs_pkg::OP_GIFT0;
        state_nxt = S_GIFT_WR;
      end
      S_GIFT_WR: begin
        cmd.op    = rrqs_pkg::OP_GIFT1;
        state_nxt = S_FIN_RD;
      end
      S_FIN_RD: begin
        cmd.op    = rrqs_pkg::OP_FINRD;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.op = rrqs_pkg::OP_FIN;
        if (stat.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/rrqs_dp.sv -----
// datapath of the round-robin quantum scheduler: slot memories, ring pointers,
// used bits, quantum register and output register; depends on rrqs_pkg
module rrqs_dp #(
  parameter int MAX_SLOTS = rrqs_pkg::MAX_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rrqs_pkg::cmd_t               cmd,
  output rrqs_pkg::stat_t              stat,
  input  logic [2:0]                   in_req_type,
  input  logic [7:0]                   in_proc_id,
  input  logic [63:0]                  in_stack_ptr,
  input  logic [1:0]                   in_new_status,
  input  logic                         in_lock_held,
  input  logic                         cfg_valid,
  input  logic [7:0]                   cfg_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [63:0]                  out_stack_ptr_out,
  output logic [7:0]                   out_running_id,
  output logic                         out_switched,
  output logic [1:0]                   out_status_code
);

  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int QW = rrqs_pkg::QUANT_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_SLOTS - 1);

  // slot memories
  logic [IW-1:0] mem_next  [MAX_SLOTS];
  logic [QW-1:0] mem_quant [MAX_SLOTS];
  logic [63:0]   mem_stack [MAX_SLOTS];
  logic [7:0]    mem_pid   [MAX_SLOTS];
  logic [1:0]    mem_state [MAX_SLOTS];

  logic [IW-1:0] rd_next_r;
  logic [QW-1:0] rd_quant_r;
  logic [63:0]   rd_stack_r;
  logic [7:0]    rd_pid_r;
  logic [1:0]    rd_state_r;

  // control state
  logic [MAX_SLOTS-1:0] used_r;
  logic [IW-1:0]        cur_r;
  logic [IW-1:0]        prev_r;
  logic                 ne_r;
  logic [7:0]           qlen_r;
  logic                 out_valid_r;

  // per-request working registers
  logic [2:0]    req_r;
  logic [7:0]    pid_r;
  logic [63:0]   sp_r;
  logic [1:0]    nst_r;
  logic          lock_r;
  logic [IW-1:0] c_r;
  logic [IW-1:0] p_r;
  logic [IW-1:0] start_r;
  logic [IW-1:0] scan_r;
  logic [1:0]    code_r;
  logic          sw_r;

  logic [63:0]   out_sp_r;
  logic [7:0]    out_id_r;
  logic          out_sw_r;
  logic [1:0]    out_code_r;

  // memory port controls
  logic          rd_en;
  logic [IW-1:0] raddr;
  logic [IW-1:0] waddr;
  logic          we_next, we_quant, we_stack, we_pid, we_state;
  logic [IW-1:0] wd_next;
  logic [QW-1:0] wd_quant;
  logic [63:0]   wd_stack;
  logic [7:0]    wd_pid;
  logic [1:0]    wd_state;

  logic [QW-1:0] qdec;
  logic [QW-1:0] qinc;
  logic          out_free;

  assign qdec = (rd_quant_r != '0) ? rd_quant_r - 1'b1 : '0;
  assign qinc = (rd_quant_r == rrqs_pkg::QUANT_MAX) ? rd_quant_r : rd_quant_r + 1'b1;
  assign out_free = !out_valid_r || out_ready;

  assign stat.ne         = ne_r;
  assign stat.req_tick   = (req_r == rrqs_pkg::REQ_TICK);
  assign stat.req_add    = (req_r == rrqs_pkg::REQ_ADD);
  assign stat.req_yield  = (req_r == rrqs_pkg::REQ_YIELD);
  assign stat.req_end    = (req_r == rrqs_pkg::REQ_END);
  assign stat.set_go     = (req_r == rrqs_pkg::REQ_SET) && (nst_r != rrqs_pkg::SS_INVALID);
  assign stat.tick_go    = (qdec == '0) && !lock_r;
  assign stat.slot_ready = (rd_state_r == rrqs_pkg::SS_READY);
  assign stat.ring_done  = (rd_next_r == start_r);
  assign stat.last       = (rd_next_r == cur_r);
  assign stat.free       = !used_r[scan_r];
  assign stat.scan_last  = (scan_r == LAST_IDX);
  assign stat.match      = used_r[scan_r] && (rd_pid_r == pid_r);
  assign stat.out_free   = out_free;

  always_comb begin
    rd_en    = 1'b0;
    raddr    = cur_r;
    waddr    = cur_r;
    we_next  = 1'b0;
    we_quant = 1'b0;
    we_stack = 1'b0;
    we_pid   = 1'b0;
    we_state = 1'b0;
    wd_next  = rd_next_r;
    wd_quant = qinc;
    wd_stack = sp_r;
    wd_pid   = pid_r;
    wd_state = rrqs_pkg::SS_READY;
    unique case (cmd.op)
      rrqs_pkg::OP_LOAD, rrqs_pkg::OP_GIFT0, rrqs_pkg::OP_FINRD: begin
        rd_en = 1'b1;
      end
      rrqs_pkg::OP_TICK0: begin
        we_quant = 1'b1;
        wd_quant = qdec;
        rd_en    = stat.tick_go;
        raddr    = rd_next_r;
      end
      rrqs_pkg::OP_RA: begin
        rd_en = !stat.slot_ready && !stat.ring_done;
        raddr = rd_next_r;
      end
      rrqs_pkg::OP_RAF: begin
        rd_en    = 1'b1;
        raddr    = start_r;
        we_quant = stat.req_tick;
        we_stack = stat.req_tick;
        wd_quant = {1'b0, qlen_r};
      end
      rrqs_pkg::OP_WALK: begin
        rd_en   = !stat.slot_ready;
        raddr   = rd_next_r;
        we_next = !stat.slot_ready && (rd_state_r == rrqs_pkg::SS_DEAD);
        waddr   = p_r;
      end
      rrqs_pkg::OP_YLD0: begin
        rd_en = 1'b1;
        raddr = rd_next_r;
      end
      rrqs_pkg::OP_YLD1: begin
        we_quant = 1'b1;
        waddr    = c_r;
      end
      rrqs_pkg::OP_YLD2: begin
        we_quant = 1'b1;
        wd_quant = '0;
      end
      rrqs_pkg::OP_END0: begin
        we_next = !stat.last;
        waddr   = prev_r;
        rd_en   = !stat.last;
        raddr   = rd_next_r;
      end
      rrqs_pkg::OP_GIFT1: begin
        we_quant = 1'b1;
      end
      rrqs_pkg::OP_ADDSCAN: begin
        waddr    = scan_r;
        we_next  = stat.free;
        we_quant = stat.free;
        we_stack = stat.free;
        we_pid   = stat.free;
        we_state = stat.free;
        wd_next  = ne_r ? rd_next_r : scan_r;
        wd_quant = {1'b0, qlen_r};
      end
      rrqs_pkg::OP_ADDLINK: begin
        we_next = 1'b1;
        wd_next = c_r;
      end
      rrqs_pkg::OP_SETRD: begin
        rd_en = 1'b1;
        raddr = scan_r;
      end
      rrqs_pkg::OP_SETCHK: begin
        we_state = stat.match;
        waddr    = scan_r;
        wd_state = nst_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we_next) begin
      mem_next[waddr] <= wd_next;
    end
    if (we_quant) begin
      mem_quant[waddr] <= wd_quant;
    end
    if (we_stack) begin
      mem_stack[waddr] <= wd_stack;
    end
    if (we_pid) begin
      mem_pid[waddr] <= wd_pid;
    end
    if (we_state) begin
      mem_state[waddr] <= wd_state;
    end
  end

  // link reads see a same-cycle link write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_next_r  <= (we_next && (waddr == raddr)) ? wd_next : mem_next[raddr];
      rd_quant_r <= mem_quant[raddr];
      rd_stack_r <= mem_stack[raddr];
      rd_pid_r   <= mem_pid[raddr];
      rd_state_r <= mem_state[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      cur_r       <= '0;
      prev_r      <= '0;
      ne_r        <= 1'b0;
      qlen_r      <= 8'd1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        qlen_r <= cfg_data;
      end
      if (cmd.op == rrqs_pkg::OP_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        rrqs_pkg::OP_WALK: begin
          if (stat.slot_ready) begin
            prev_r <= p_r;
            cur_r  <= c_r;
          end else if (rd_state_r == rrqs_pkg::SS_DEAD) begin
            used_r[c_r] <= 1'b0;
          end
        end
        rrqs_pkg::OP_END0: begin
          used_r[cur_r] <= 1'b0;
          if (stat.last) begin
            ne_r   <= 1'b0;
            cur_r  <= '0;
            prev_r <= '0;
          end else begin
            cur_r <= rd_next_r;
          end
        end
        rrqs_pkg::OP_ADDSCAN: begin
          if (stat.free) begin
            used_r[scan_r] <= 1'b1;
            if (!ne_r) begin
              cur_r  <= scan_r;
              prev_r <= scan_r;
              ne_r   <= 1'b1;
            end
          end
        end
        rrqs_pkg::OP_ADDLINK: begin
          if (prev_r == cur_r) begin
            prev_r <= c_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == rrqs_pkg::OP_FIN && out_free) begin
      out_sp_r   <= sw_r ? rd_stack_r : sp_r;
      out_id_r   <= ne_r ? rd_pid_r : 8'd0;
      out_sw_r   <= sw_r;
      out_code_r <= code_r;
    end
    unique case (cmd.op)
      rrqs_pkg::OP_LOAD: begin
        req_r  <= in_req_type;
        pid_r  <= in_proc_id;
        sp_r   <= in_stack_ptr;
        nst_r  <= in_new_status;
        lock_r <= in_lock_held;
        scan_r <= '0;
        sw_r   <= 1'b0;
        code_r <= (in_req_type >= rrqs_pkg::REQ_SET && !ne_r) ? rrqs_pkg::ST_EMPTY
                                                               : rrqs_pkg::ST_OK;
      end
      rrqs_pkg::OP_EMPTY: begin
        code_r <= rrqs_pkg::ST_EMPTY;
      end
      rrqs_pkg::OP_TICK0: begin
        if (stat.tick_go) begin
          start_r <= rd_next_r;
          c_r     <= rd_next_r;
        end
      end
      rrqs_pkg::OP_RA: begin
        if (!stat.slot_ready) begin
          if (stat.ring_done) begin
            code_r <= rrqs_pkg::ST_NO_READY;
          end else begin
            c_r <= rd_next_r;
          end
        end
      end
      rrqs_pkg::OP_RAF: begin
        c_r <= start_r;
        p_r <= stat.req_tick ? cur_r : prev_r;
      end
      rrqs_pkg::OP_WALK: begin
        if (stat.slot_ready) begin
          if (stat.req_tick) begin
            sw_r <= (c_r != cur_r);
          end
        end else begin
          c_r <= rd_next_r;
          if (rd_state_r != rrqs_pkg::SS_DEAD) begin
            p_r <= c_r;
          end
        end
      end
      rrqs_pkg::OP_YLD0: begin
        c_r <= rd_next_r;
      end
      rrqs_pkg::OP_END0: begin
        if (stat.last) begin
          code_r <= rrqs_pkg::ST_EMPTY;
        end else begin
          start_r <= rd_next_r;
          c_r     <= rd_next_r;
          sw_r    <= 1'b1;
        end
      end
      rrqs_pkg::OP_ADDSCAN: begin
        priority if (stat.free) begin
          c_r <= scan_r;
          if (!ne_r) begin
            sw_r <= 1'b1;
          end
        end else if (stat.scan_last) begin
          code_r <= rrqs_pkg::ST_FULL;
        end else begin
          scan_r <= scan_r + 1'b1;
        end
      end
      rrqs_pkg::OP_SETCHK: begin
        if (!stat.match && !stat.scan_last) begin
          scan_r <= scan_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_stack_ptr_out = out_sp_r;
  assign out_running_id    = out_id_r;
  assign out_switched      = out_sw_r;
  assign out_status_code   = out_code_r;

endmodule

// ----- src/round_robin_quantum_scheduler.sv -----
// top level of the round-robin quantum scheduler
// depends on rrqs_pkg, rrqs_ctrl and rrqs_dp
//
//   channel  dir  handshake              payload
//   in       in   in_valid / in_ready    req_type, proc_id, stack_ptr, new_status, lock_held
//   out      out  out_valid / out_ready  stack_ptr_out, running_id, switched, status_code
//   cfg      in   cfg_valid / cfg_ready  data (quantum length)
//
// one request at a time, in steps: load, dispatch, slot read, result
// switching tick and end of one of several slots: slots are read in a search for a ready one,
//   then if one is found the ring is walked to it; end adds the gift; yield rewrites quantums
// add: scans slots for a free one, then links it into a nonempty ring
// set status: reads and checks slots in turn until the process id matches or the last slot
// synchronous reset, used bits clear at once; the result step waits for a free output register
module round_robin_quantum_scheduler #(
  parameter int MAX_SLOTS = rrqs_pkg::MAX_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_proc_id,
  input  logic [63:0] in_stack_ptr,
  input  logic [1:0]  in_new_status,
  input  logic        in_lock_held,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_stack_ptr_out,
  output logic [7:0]  out_running_id,
  output logic        out_switched,
  output logic [1:0]  out_status_code,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  rrqs_pkg::cmd_t  cmd;
  rrqs_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  rrqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rrqs_dp #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_req_type       (in_req_type),
    .in_proc_id        (in_proc_id),
    .in_stack_ptr      (in_stack_ptr),
    .in_new_status     (in_new_status),
    .in_lock_held      (in_lock_held),
    .cfg_valid         (cfg_valid),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_stack_ptr_out (out_stack_ptr_out),
    .out_running_id    (out_running_id),
    .out_switched      (out_switched),
    .out_status_code   (out_status_code)
  );

endmodule

// ----- src/rrqs_checker.sv -----
// port-level checks for the round-robin quantum scheduler, bound to the top level
// depends on round_robin_quantum_scheduler_macros.svh and rrqs_pkg
`include "round_robin_quantum_scheduler_macros.svh"

module rrqs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_stack_ptr_out,
  input logic [7:0]  out_running_id,
  input logic        out_switched,
  input logic [1:0]  out_status_code
);

  `RRQS_ASSERT_IMP(a_full_no_switch, out_valid && (out_status_code == rrqs_pkg::ST_FULL), !out_switched)
  `RRQS_ASSERT_IMP(a_empty_no_id, out_valid && (out_status_code == rrqs_pkg::ST_EMPTY), out_running_id == 8'd0)
  `RRQS_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready)
  `RRQS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_stack_ptr_out))

endmodule

bind round_robin_quantum_scheduler rrqs_checker u_rrqs_checker (.*);
